// ===== rtl/bfls_pkg.sv =====
package bfls_pkg;

  // Default geometry of the scanner.
  localparam int unsigned WORD_BITS_DEF = 64;
  localparam int unsigned MAX_BITS_DEF  = 1024;

  // Register map (byte addresses on the APB port).
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-1:0] REG_BIT_COUNT_ADDR = 3'd0;

  // Per-word hit flags from the word scanner.
  typedef struct packed {
    logic any_set;
    logic any_clear;
  } bfls_hit_t;

endpackage

// ===== rtl/bfls_word_scan.sv =====
module bfls_word_scan #(
  parameter int unsigned WORD_BITS = bfls_pkg::WORD_BITS_DEF,
  localparam int unsigned OFF_W    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1,
  localparam int unsigned VB_W     = $clog2(WORD_BITS + 1)
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [VB_W-1:0]      valid_bits_i,
  output logic [OFF_W-1:0]     lo_set_o,
  output logic [OFF_W-1:0]     hi_set_o,
  output logic [OFF_W-1:0]     lo_clear_o,
  output logic [OFF_W-1:0]     hi_clear_o,
  output bfls_pkg::bfls_hit_t  hit_o
);
  import bfls_pkg::*;

  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] set_bits;
  logic [WORD_BITS-1:0] clr_bits;

  // Thermometer mask of the bits below the valid count.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      valid_mask[i] = (VB_W'(i) < valid_bits_i);
    end
  end

  assign set_bits = word_i & valid_mask;
  assign clr_bits = ~word_i & valid_mask;

  // Four priority encoders; the later hit in loop order wins.
  always_comb begin
    lo_set_o   = '0;
    hi_set_o   = '0;
    lo_clear_o = '0;
    hi_clear_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (set_bits[i]) lo_set_o = OFF_W'(i);
      if (clr_bits[i]) lo_clear_o = OFF_W'(i);
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      if (set_bits[i]) hi_set_o = OFF_W'(i);
      if (clr_bits[i]) hi_clear_o = OFF_W'(i);
    end
  end

  assign hit_o.any_set   = |set_bits;
  assign hit_o.any_clear = |clr_bits;

endmodule

// ===== rtl/bitmap_first_last_bit_scan.sv =====
// Channel   | Dir | Beat contents
// ----------+-----+---------------------------------------------------------
// s_axis    | in  | one bitmap word, lowest word of the bitmap first
// m_axis    | out | first_set, first_clear, last_set, last_clear (-1 = none)
// apb       | cfg | bit_count at byte address 0
//
// One word beat is taken per cycle unless the input stalls. A word passes
// through an input register, then the masked priority encoders update the
// running positions; the last word of a bitmap loads the result register,
// which drives m_axis_tvalid. Input stalls only when a result is still held
// in the output register and a new result is due. Reset clears the scan state
// and sets bit_count to MAX_BITS.
module bitmap_first_last_bit_scan #(
  parameter int unsigned WORD_BITS = bfls_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_BITS  = bfls_pkg::MAX_BITS_DEF,
  localparam int unsigned IN_W     = ((WORD_BITS + 7) / 8) * 8,
  localparam int unsigned IX_W     = $clog2(MAX_BITS),
  localparam int unsigned POS_W    = IX_W + 1,
  localparam int unsigned OUT_W    = ((4 * POS_W + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // s_axis_tdata: word
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [IN_W-1:0]                     s_axis_tdata,
  // m_axis_tdata: first_set, first_clear, last_set, last_clear (low to high)
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [OUT_W-1:0]                    m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bfls_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import bfls_pkg::*;

  localparam int unsigned CNT_W = IX_W + 1;
  localparam int unsigned OFF_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned VB_W  = $clog2(WORD_BITS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BITS);
  localparam logic [CNT_W:0]   WORD_INC = (CNT_W + 1)'(WORD_BITS);

  // ---------------- configuration ----------------
  logic [CNT_W-1:0] bit_count_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_BIT_COUNT_ADDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q <= MAX_CNT;
    end else if (cfg_wr) begin
      bit_count_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_BIT_COUNT_ADDR) begin
      prdata[CNT_W-1:0] = bit_count_q;
    end
  end

  // ---------------- input register ----------------
  logic                 in_vld_q;
  logic [WORD_BITS-1:0] in_word_q;
  logic                 in_adv;

  assign s_axis_tready = !in_vld_q || in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_word_q <= s_axis_tdata[WORD_BITS-1:0];
    end
  end

  // ---------------- word scan ----------------
  logic [CNT_W-1:0] base_q;
  logic [CNT_W-1:0] count_sat;
  logic [CNT_W-1:0] remain;
  logic [VB_W-1:0]  valid_bits;
  logic [CNT_W:0]   base_end;
  logic             last_word;

  logic [OFF_W-1:0] lo_set, hi_set, lo_clear, hi_clear;
  bfls_hit_t        hit;

  assign count_sat = (bit_count_q > MAX_CNT) ? MAX_CNT : bit_count_q;
  assign remain    = (count_sat > base_q) ? (count_sat - base_q) : '0;
  assign valid_bits = (remain > CNT_W'(WORD_BITS)) ? VB_W'(WORD_BITS) : VB_W'(remain);
  assign base_end  = {1'b0, base_q} + WORD_INC;
  assign last_word = (base_end >= {1'b0, count_sat});

  bfls_word_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word_i       (in_word_q),
    .valid_bits_i (valid_bits),
    .lo_set_o     (lo_set),
    .hi_set_o     (hi_set),
    .lo_clear_o   (lo_clear),
    .hi_clear_o   (hi_clear),
    .hit_o        (hit)
  );

  // ---------------- running positions ----------------
  logic            fs_ok_q, fc_ok_q, ls_ok_q, lc_ok_q;
  logic [IX_W-1:0] fs_q, fc_q, ls_q, lc_q;
  logic            fs_ok_d, fc_ok_d, ls_ok_d, lc_ok_d;
  logic [IX_W-1:0] fs_d, fc_d, ls_d, lc_d;
  logic [IX_W-1:0] base_ix;

  assign base_ix = base_q[IX_W-1:0];

  // Merge this word's hits into the running state; first positions stick.
  always_comb begin
    fs_ok_d = fs_ok_q;
    fc_ok_d = fc_ok_q;
    ls_ok_d = ls_ok_q;
    lc_ok_d = lc_ok_q;
    fs_d    = fs_q;
    fc_d    = fc_q;
    ls_d    = ls_q;
    lc_d    = lc_q;
    if (hit.any_set) begin
      if (!fs_ok_q) begin
        fs_ok_d = 1'b1;
        fs_d    = base_ix + IX_W'(lo_set);
      end
      ls_ok_d = 1'b1;
      ls_d    = base_ix + IX_W'(hi_set);
    end
    if (hit.any_clear) begin
      if (!fc_ok_q) begin
        fc_ok_d = 1'b1;
        fc_d    = base_ix + IX_W'(lo_clear);
      end
      lc_ok_d = 1'b1;
      lc_d    = base_ix + IX_W'(hi_clear);
    end
  end

  // Advance a word unless it ends a bitmap while the result slot is full and m_axis_tready is low.
  logic out_vld_q;

  assign in_adv = in_vld_q && (!last_word || !out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      fs_ok_q <= 1'b0;
      fc_ok_q <= 1'b0;
      ls_ok_q <= 1'b0;
      lc_ok_q <= 1'b0;
    end else if (in_adv) begin
      if (last_word) begin
        base_q  <= '0;
        fs_ok_q <= 1'b0;
        fc_ok_q <= 1'b0;
        ls_ok_q <= 1'b0;
        lc_ok_q <= 1'b0;
      end else begin
        base_q  <= base_end[CNT_W-1:0];
        fs_ok_q <= fs_ok_d;
        fc_ok_q <= fc_ok_d;
        ls_ok_q <= ls_ok_d;
        lc_ok_q <= lc_ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      fs_q <= fs_d;
      fc_q <= fc_d;
      ls_q <= ls_d;
      lc_q <= lc_d;
    end
  end

  // ---------------- result register ----------------
  logic             res_load;
  logic [POS_W-1:0] fs_out, fc_out, ls_out, lc_out;
  logic [OUT_W-1:0] res_q;

  assign res_load = in_adv && last_word;

  // Not found reads as -1 (all ones).
  assign fs_out = fs_ok_d ? {1'b0, fs_d} : '1;
  assign fc_out = fc_ok_d ? {1'b0, fc_d} : '1;
  assign ls_out = ls_ok_d ? {1'b0, ls_d} : '1;
  assign lc_out = lc_ok_d ? {1'b0, lc_d} : '1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= OUT_W'({lc_out, ls_out, fc_out, fs_out});
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;

endmodule
